### src/srsw_pkg.sv
// Shared constants and types for the selective-repeat sender window.
// Holds store geometry, field widths, stream packing widths and the action codes.
// No dependencies.
package srsw_pkg;

    // Store geometry.
    localparam int MAX_PACKETS = 16;
    localparam int IDX_W       = $clog2(MAX_PACKETS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int MAX_WINDOW  = 8;
    localparam int STAMP_BITS  = 16;

    // Field widths.
    localparam int ACTION_W  = 2;
    localparam int DATA_W    = 32;
    localparam int SEQ_W     = 4;
    localparam int TIMEOUT_W = 15;
    localparam int WIN_W     = 4;
    localparam int CMP_W     = (STAMP_BITS > TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = ((DATA_W + SEQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SEQ_W + DATA_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = TIMEOUT_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW  = 1'b1;

    // Input item kinds.
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

endpackage

### src/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window: packet store, ack tracking and timed (re)transmission.
// One sequencer walks the window through a single read port and one elapsed-time compare.
// Depends on srsw_pkg.
//
// Usage:
//   The slave channel takes one item per transfer. s_tuser carries the action
//   (load, tick, ack, clear); s_tdata carries the data word and the ack number.
//   The master channel delivers one transfer per packet to send, with m_tlast on
//   the final packet of a tick. Only ticks produce transfers.
//   Load and clear complete in the idle state. An ack marks its packet, then the
//   base slides past each acknowledged packet in turn. A tick starts a scan that
//   reads each window entry through the single read port, then compares its timer
//   and stamps it, and ends by handing over the final packet. s_tready is low
//   while an item is in work. When the receiver stalls, the block holds one packet
//   in the output register and one pending, then waits. Reset clears the flags,
//   counters and window base and sets timeout_ticks to 2 and the window size to 4.
//   The user must write the configuration port only while idle; the block does
//   not enforce this.
module selective_repeat_sender_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srsw_pkg::S_TDATA_W-1:0]      s_tdata,   // data_value[31:0], ack_number[35:32]
    input  logic [srsw_pkg::ACTION_W-1:0]       s_tuser,   // action[1:0]
    // Packets to transmit.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srsw_pkg::M_TDATA_W-1:0]      m_tdata,   // seq_number[3:0], payload[35:4]
    output logic                                m_tuser,   // is_retransmit[0]
    output logic                                m_tlast,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [srsw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import srsw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SLIDE = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIMEOUT_W-1:0]   timeout_reg, timeout_next;
    logic [WIN_W-1:0]       window_reg, window_next;
    logic [MAX_PACKETS-1:0] acked_reg, acked_next;
    logic [MAX_PACKETS-1:0] sent_reg, sent_next;
    logic [STAMP_BITS-1:0]  tick_reg, tick_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [CNT_W-1:0]       loaded_reg, loaded_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       end_reg, end_next;

    // Pending packet: found due, not yet known whether it closes the tick.
    logic                   pend_valid_reg, pend_valid_next;
    logic [SEQ_W-1:0]       pend_seq_reg, pend_seq_next;
    logic [DATA_W-1:0]      pend_data_reg, pend_data_next;
    logic                   pend_retx_reg, pend_retx_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [SEQ_W-1:0]       out_seq_reg, out_seq_next;
    logic [DATA_W-1:0]      out_data_reg, out_data_next;
    logic                   out_retx_reg, out_retx_next;
    logic                   out_last_reg, out_last_next;

    // Stores and their registered read data.
    logic [DATA_W-1:0]      payload_mem [MAX_PACKETS];
    logic [STAMP_BITS-1:0]  stamp_mem [MAX_PACKETS];
    logic [DATA_W-1:0]      rd_data_reg;
    logic [STAMP_BITS-1:0]  rd_stamp_reg;

    action_t                action;
    logic [DATA_W-1:0]      data_in;
    logic [SEQ_W-1:0]       ack_in;
    logic                   in_xfer;
    logic                   out_free;
    logic                   load_we;
    logic                   stamp_we;
    logic [IDX_W-1:0]       idx_lo;
    logic [WIN_W-1:0]       win_sat;
    logic [CNT_W:0]         span;
    logic [STAMP_BITS-1:0]  elapsed;
    logic                   due;
    logic [CNT_W-1:0]       idx_inc;

    assign action   = action_t'(s_tuser);
    assign data_in  = s_tdata[DATA_W-1:0];
    assign ack_in   = s_tdata[DATA_W+SEQ_W-1:DATA_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_lo   = idx_reg[IDX_W-1:0];
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign load_we  = in_xfer && (action == ACT_LOAD) && !loaded_reg[CNT_W-1];

    // Effective window size, saturated to one through the largest window.
    always_comb begin
        if (window_reg == '0) begin
            win_sat = WIN_W'(1);
        end else if (window_reg > WIN_W'(MAX_WINDOW)) begin
            win_sat = WIN_W'(MAX_WINDOW);
        end else begin
            win_sat = window_reg;
        end
    end

    assign span = {1'b0, base_reg} + (CNT_W+1)'(win_sat);

    // Timer compare for the entry whose stamp was just read.
    assign elapsed = tick_reg - rd_stamp_reg;
    assign due = !acked_reg[idx_lo] &&
                 (!sent_reg[idx_lo] || (CMP_W'(elapsed) >= CMP_W'(timeout_reg)));
    assign stamp_we = (state_reg == ST_EVAL) && due && (!pend_valid_reg || out_free);

    // Sequencer and next-state logic.
    always_comb begin
        state_next      = state_reg;
        timeout_next    = timeout_reg;
        window_next     = window_reg;
        acked_next      = acked_reg;
        sent_next       = sent_reg;
        tick_next       = tick_reg;
        base_next       = base_reg;
        loaded_next     = loaded_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        pend_data_next  = pend_data_reg;
        pend_retx_next  = pend_retx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_seq_next    = out_seq_reg;
        out_data_next   = out_data_reg;
        out_retx_next   = out_retx_reg;
        out_last_next   = out_last_reg;

        // Configuration writes.
        if (cfg_we) begin
            if (cfg_addr == REG_TIMEOUT) begin
                timeout_next = cfg_wdata[TIMEOUT_W-1:0];
            end else begin
                window_next = cfg_wdata[WIN_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (action)
                        ACT_LOAD: begin
                            if (!loaded_reg[CNT_W-1]) begin
                                acked_next[loaded_reg[IDX_W-1:0]] = 1'b0;
                                sent_next[loaded_reg[IDX_W-1:0]]  = 1'b0;
                                loaded_next = loaded_reg + CNT_W'(1);
                            end
                        end
                        ACT_TICK: begin
                            tick_next = tick_reg + STAMP_BITS'(1);
                            idx_next  = base_reg;
                            if (span > (CNT_W+1)'(loaded_reg)) begin
                                end_next = loaded_reg;
                            end else begin
                                end_next = span[CNT_W-1:0];
                            end
                            if ((span > (CNT_W+1)'(base_reg)) && (loaded_reg > base_reg)) begin
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_FLUSH;
                            end
                        end
                        ACT_ACK: begin
                            if ((CNT_W)'(ack_in) < loaded_reg) begin
                                acked_next[ack_in[IDX_W-1:0]] = 1'b1;
                            end
                            state_next = ST_SLIDE;
                        end
                        ACT_CLEAR: begin
                            acked_next  = '0;
                            sent_next   = '0;
                            base_next   = '0;
                            loaded_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SLIDE: begin
                // Move the base past one acknowledged packet per cycle.
                if ((base_reg < loaded_reg) && acked_reg[base_reg[IDX_W-1:0]]) begin
                    base_next = base_reg + CNT_W'(1);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!due || !pend_valid_reg || out_free) begin
                    if (due) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_seq_next   = pend_seq_reg;
                            out_data_next  = pend_data_reg;
                            out_retx_next  = pend_retx_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_seq_next   = SEQ_W'(idx_reg);
                        pend_data_next  = rd_data_reg;
                        pend_retx_next  = sent_reg[idx_lo];
                        sent_next[idx_lo] = 1'b1;
                    end
                    idx_next = idx_inc;
                    if (idx_inc < end_reg) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                // Hand over the final packet of the tick with tlast set.
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_seq_next    = pend_seq_reg;
                    out_data_next   = pend_data_reg;
                    out_retx_next   = pend_retx_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= TIMEOUT_W'(2);
            window_reg     <= WIN_W'(4);
            acked_reg      <= '0;
            sent_reg       <= '0;
            tick_reg       <= '0;
            base_reg       <= '0;
            loaded_reg     <= '0;
            idx_reg        <= '0;
            end_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            window_reg     <= window_next;
            acked_reg      <= acked_next;
            sent_reg       <= sent_next;
            tick_reg       <= tick_next;
            base_reg       <= base_next;
            loaded_reg     <= loaded_next;
            idx_reg        <= idx_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers of the pending slot and the output stage.
    always_ff @(posedge aclk) begin
        pend_seq_reg  <= pend_seq_next;
        pend_data_reg <= pend_data_next;
        pend_retx_reg <= pend_retx_next;
        out_seq_reg   <= out_seq_next;
        out_data_reg  <= out_data_next;
        out_retx_reg  <= out_retx_next;
        out_last_reg  <= out_last_next;
    end

    // Payload store: written by loads, read once per scanned entry.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            payload_mem[loaded_reg[IDX_W-1:0]] <= data_in;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= payload_mem[idx_lo];
        end
    end

    // Send-time store: stamped when a packet is emitted.
    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[idx_lo] <= tick_reg;
        end
        if (state_reg == ST_READ) begin
            rd_stamp_reg <= stamp_mem[idx_lo];
        end
    end

    // Output channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-SEQ_W){1'b0}}, out_data_reg, out_seq_reg};
    assign m_tuser  = out_retx_reg;
    assign m_tlast  = out_last_reg;

endmodule

### verif/testbench.sv
// Self-checking testbench for selective_repeat_sender_window.
// Runs directed and random load, tick, ack and clear traffic against an in-bench window predictor.
// Depends on srsw_pkg and the selective_repeat_sender_window RTL.
module testbench;
    import srsw_pkg::*;

    localparam int SETTLE_CYCLES   = 2 * MAX_WINDOW + 8;
    localparam int HOLD_CYCLES     = 160;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int NUM_PHASES      = 5;
    localparam int RUN_LIMIT       = 100_000_000;

    // One packet as seen on the master channel.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] payload;
        logic              retx;
        logic              last;
    } sent_pkt_t;

    // One row of the directed plan: an item (possibly repeated) or a register write.
    typedef struct {
        bit                    reg_row;
        logic [CFG_ADDR_W-1:0] reg_idx;
        action_t               act;
        logic [DATA_W-1:0]     data;
        logic [SEQ_W-1:0]      ackn;
        int                    count;
        bit                    typed;
        sent_pkt_t             want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [ACTION_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor state: a shadow copy of the sender window.
    logic [DATA_W-1:0]     shadow_payload [MAX_PACKETS];
    logic                  shadow_acked   [MAX_PACKETS];
    logic                  shadow_sent    [MAX_PACKETS];
    logic [STAMP_BITS-1:0] shadow_stamp   [MAX_PACKETS];
    logic [STAMP_BITS-1:0] shadow_tick;
    logic [CNT_W-1:0]      shadow_base;
    logic [CNT_W-1:0]      shadow_loaded;
    logic [TIMEOUT_W-1:0]  shadow_timeout;
    logic [WIN_W-1:0]      shadow_window;

    sent_pkt_t tick_pkts[$];
    sent_pkt_t pending_pkts[$];
    plan_row_t plan[$];

    bit        typed_on;
    sent_pkt_t typed_want;
    int        hold_asked;
    int        mismatch_count;
    int        items_accepted;
    int        ticks_accepted;
    int        pkts_checked;
    int        resends_seen;

    selective_repeat_sender_window dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Run did not finish in time, %0d packets still outstanding.",
                 pending_pkts.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Window size as the block uses it: zero acts as one, large values as the maximum.
    function automatic int eff_window();
        if (shadow_window == 0) begin
            return 1;
        end
        if (shadow_window > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(shadow_window);
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < MAX_PACKETS; i++) begin
            shadow_payload[i] = '0;
            shadow_acked[i]   = 1'b0;
            shadow_sent[i]    = 1'b0;
            shadow_stamp[i]   = '0;
        end
        shadow_tick    = '0;
        shadow_base    = '0;
        shadow_loaded  = '0;
        shadow_timeout = TIMEOUT_W'(2);
        shadow_window  = WIN_W'(4);
    endfunction

    // Advances the shadow window by one accepted item; a tick leaves its packets in tick_pkts.
    function automatic void window_step(action_t act, logic [DATA_W-1:0] data,
                                        logic [SEQ_W-1:0] ackn);
        int                    stop;
        logic [STAMP_BITS-1:0] elapsed;
        sent_pkt_t             pkt;
        tick_pkts.delete();
        case (act)
            ACT_LOAD: begin
                if (shadow_loaded < MAX_PACKETS) begin
                    shadow_payload[shadow_loaded[IDX_W-1:0]] = data;
                    shadow_acked[shadow_loaded[IDX_W-1:0]]   = 1'b0;
                    shadow_sent[shadow_loaded[IDX_W-1:0]]    = 1'b0;
                    shadow_loaded++;
                end
            end
            ACT_TICK: begin
                shadow_tick = shadow_tick + 1'b1;
                stop = int'(shadow_base) + eff_window();
                if (stop > int'(shadow_loaded)) begin
                    stop = int'(shadow_loaded);
                end
                for (int i = int'(shadow_base); i < stop && i < MAX_PACKETS; i++) begin
                    elapsed = shadow_tick - shadow_stamp[i];
                    if (!shadow_acked[i] && (!shadow_sent[i] || elapsed >= shadow_timeout)) begin
                        pkt.seq     = SEQ_W'(i);
                        pkt.payload = shadow_payload[i];
                        pkt.retx    = shadow_sent[i];
                        pkt.last    = 1'b0;
                        tick_pkts.insert(tick_pkts.size(), pkt);
                        shadow_sent[i]  = 1'b1;
                        shadow_stamp[i] = shadow_tick;
                    end
                end
                if (tick_pkts.size() > 0) begin
                    tick_pkts[tick_pkts.size() - 1].last = 1'b1;
                end
            end
            ACT_ACK: begin
                if (ackn < shadow_loaded) begin
                    shadow_acked[ackn] = 1'b1;
                end
                while (shadow_base < shadow_loaded && shadow_acked[shadow_base[IDX_W-1:0]]) begin
                    shadow_base++;
                end
            end
            default: begin
                for (int i = 0; i < MAX_PACKETS; i++) begin
                    shadow_acked[i] = 1'b0;
                    shadow_sent[i]  = 1'b0;
                end
                shadow_base   = '0;
                shadow_loaded = '0;
            end
        endcase
    endfunction

    function automatic void flag_mismatch(string what, sent_pkt_t want, sent_pkt_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch, %s: expected seq %0d payload %h retx %0b last %0b,",
                     what, want.seq, want.payload, want.retx, want.last);
            $display("    got seq %0d payload %h retx %0b last %0b at %0t",
                     got.seq, got.payload, got.retx, got.last, $time);
        end
    endfunction

    // Sampling side: feed accepted items to the predictor and check every packet transfer.
    always @(posedge aclk) begin : check_side
        sent_pkt_t got;
        sent_pkt_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                window_step(action_t'(s_tuser), s_tdata[DATA_W-1:0],
                            s_tdata[DATA_W+SEQ_W-1:DATA_W]);
                items_accepted++;
                if (action_t'(s_tuser) == ACT_TICK) begin
                    ticks_accepted++;
                end
                if (typed_on) begin
                    pending_pkts.insert(pending_pkts.size(), typed_want);
                end else begin
                    foreach (tick_pkts[n]) begin
                        pending_pkts.insert(pending_pkts.size(), tick_pkts[n]);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.seq     = m_tdata[SEQ_W-1:0];
                got.payload = m_tdata[SEQ_W+DATA_W-1:SEQ_W];
                got.retx    = m_tuser;
                got.last    = m_tlast;
                pkts_checked++;
                if (pending_pkts.size() == 0) begin
                    flag_mismatch("packet with none expected", '0, got);
                end else begin
                    want = pending_pkts.pop_front();
                    if (got.retx === 1'b1) begin
                        resends_seen++;
                    end
                    if (got.seq !== want.seq || got.payload !== want.payload
                            || got.retx !== want.retx || got.last !== want.last) begin
                        flag_mismatch("packet fields", want, got);
                    end
                end
            end
        end
    end

    // Receiver: ready patterns of its own, plus a long hold-off on request.
    initial begin : receiver
        int mode;
        int span;
        int hold_done;
        hold_done = 0;
        m_tready  = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            for (int c = 0; c < span; c++) begin
                @(negedge aclk);
                if (hold_asked != hold_done) begin
                    hold_done = hold_asked;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((c % 4) == 0);
                endcase
            end
        end
    end

    function automatic void add_item(action_t act, logic [DATA_W-1:0] data,
                                     logic [SEQ_W-1:0] ackn, int count);
        plan_row_t r;
        r.reg_row = 1'b0;
        r.reg_idx = REG_TIMEOUT;
        r.act     = act;
        r.data    = data;
        r.ackn    = ackn;
        r.count   = count;
        r.typed   = 1'b0;
        r.want    = '0;
        plan.insert(plan.size(), r);
    endfunction

    // A tick whose single packet is known outright.
    function automatic void add_tick_want(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] payload,
                                          logic retx);
        plan_row_t r;
        r.reg_row = 1'b0;
        r.reg_idx = REG_TIMEOUT;
        r.act     = ACT_TICK;
        r.data    = $urandom;
        r.ackn    = SEQ_W'($urandom);
        r.count   = 1;
        r.typed   = 1'b1;
        r.want    = '{seq: seq, payload: payload, retx: retx, last: 1'b1};
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r.reg_row = 1'b1;
        r.reg_idx = idx;
        r.act     = ACT_LOAD;
        r.data    = DATA_W'(value);
        r.ackn    = '0;
        r.count   = 0;
        r.typed   = 1'b0;
        r.want    = '0;
        plan.insert(plan.size(), r);
    endfunction

    // Offers one item from a falling edge and returns at the falling edge after its transfer.
    task automatic send_item(action_t act, logic [DATA_W-1:0] data, logic [SEQ_W-1:0] ackn,
                             bit typed, sent_pkt_t want);
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= S_TDATA_W'({ackn, data});
        typed_on   <= typed;
        typed_want <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Waits until every expected packet has arrived and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pkts.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TIMEOUT) begin
            shadow_timeout = value;
        end else begin
            shadow_window = value[WIN_W-1:0];
        end
        @(negedge aclk);
    endtask

    // Random item, mostly well-formed: loads while there is room, acks inside the window.
    task automatic pick_item(output action_t act, output logic [DATA_W-1:0] data,
                             output logic [SEQ_W-1:0] ackn);
        int r;
        int span;
        bit full;
        r    = $urandom_range(0, 99);
        full = (shadow_loaded == MAX_PACKETS);
        data = $urandom;
        ackn = SEQ_W'($urandom);
        if (r < 3 || (full && shadow_base >= MAX_PACKETS - 2 && r < 60)) begin
            act = ACT_CLEAR;
        end else if (r < 33) begin
            act = (full && r >= 8) ? ACT_TICK : ACT_LOAD;
        end else if (r < 65) begin
            act = ACT_TICK;
        end else begin
            act  = ACT_ACK;
            span = int'(shadow_loaded) - int'(shadow_base);
            if (span > eff_window()) begin
                span = eff_window();
            end
            if (span > 0 && $urandom_range(0, 9) < 8) begin
                ackn = SEQ_W'(int'(shadow_base) + $urandom_range(0, span - 1));
            end
        end
    endtask

    // Main sequence: reset, directed plan, then random phases.
    initial begin : stimulus
        action_t              act;
        logic [DATA_W-1:0]    data;
        logic [SEQ_W-1:0]     ackn;
        int                   counted;
        int                   burst_left;
        int                   gap;
        bit                   drained;
        logic [CFG_DATA_W-1:0] tmo_set [NUM_PHASES];
        logic [CFG_DATA_W-1:0] win_set [NUM_PHASES];

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        typed_on       = 1'b0;
        typed_want     = '0;
        hold_asked     = 0;
        mismatch_count = 0;
        items_accepted = 0;
        ticks_accepted = 0;
        pkts_checked   = 0;
        resends_seen   = 0;
        shadow_reset();

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed plan, starting from the reset settings (timeout 2, window 4).
        add_item(ACT_TICK, 32'h0, 4'd0, 1);            // tick on an empty store
        add_item(ACT_ACK, 32'h0, 4'd0, 1);             // ack with nothing loaded
        add_item(ACT_LOAD, 32'hFFFF_FFFF, 4'd0, 1);
        add_tick_want(4'd0, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_LOAD, 32'h0000_0000, 4'hF, 1);
        add_tick_want(4'd1, 32'h0000_0000, 1'b0);
        add_tick_want(4'd0, 32'hFFFF_FFFF, 1'b1);      // first packet times out
        add_item(ACT_ACK, 32'h0, 4'hF, 1);             // beyond the loaded count
        add_item(ACT_ACK, 32'h0, 4'd1, 1);
        add_item(ACT_ACK, 32'h0, 4'd1, 1);             // same ack again
        add_item(ACT_ACK, 32'h0, 4'd0, 1);             // base slides over both
        add_item(ACT_TICK, 32'h0, 4'd0, 1);
        add_item(ACT_LOAD, 32'hA5A5_5A5A, 4'd0, 1);
        add_item(ACT_LOAD, 32'h5A5A_A5A5, 4'd0, 1);
        add_reg(REG_WINDOW, 15'h7FF0);                 // zero window with high bits set
        add_tick_want(4'd2, 32'hA5A5_5A5A, 1'b0);
        add_reg(REG_TIMEOUT, 15'd0);                   // resend on every tick
        add_tick_want(4'd2, 32'hA5A5_5A5A, 1'b1);
        add_reg(REG_WINDOW, 15'h000F);                 // saturates at the maximum window
        add_item(ACT_TICK, 32'h0, 4'd0, 1);
        add_item(ACT_CLEAR, 32'h0, 4'd0, 1);
        add_item(ACT_TICK, 32'h0, 4'd0, 1);
        add_item(ACT_LOAD, 32'hC0DE_0000, 4'd0, MAX_PACKETS + 1);  // last one finds it full
        add_item(ACT_TICK, 32'h0, 4'd0, 1);            // full window goes out
        add_reg(REG_TIMEOUT, 15'h7FFF);
        add_item(ACT_TICK, 32'h0, 4'd0, 1);            // nothing is due yet
        add_item(ACT_ACK, 32'h0, 4'd3, 1);
        add_item(ACT_ACK, 32'h0, 4'd0, 1);
        add_tick_want(4'd8, 32'hC0DE_0008, 1'b0);
        add_reg(REG_WINDOW, 15'd4);

        foreach (plan[k]) begin
            if (plan[k].reg_row) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].data[CFG_DATA_W-1:0]);
            end else begin
                for (int j = 0; j < plan[k].count; j++) begin
                    send_item(plan[k].act, plan[k].data + DATA_W'(j), plan[k].ackn,
                              plan[k].typed, plan[k].want);
                end
            end
        end

        // Random phases, each with its own register setting.
        tmo_set[0] = 15'd1;
        win_set[0] = 15'd8;
        tmo_set[1] = 15'd0;
        win_set[1] = {11'($urandom), 4'd1};
        tmo_set[2] = CFG_DATA_W'($urandom_range(2, 6));
        win_set[2] = {11'($urandom), 4'($urandom_range(3, 15))};
        tmo_set[3] = CFG_DATA_W'($urandom);
        win_set[3] = {11'($urandom), 4'($urandom)};
        tmo_set[4] = 15'd2;
        win_set[4] = 15'd4;
        burst_left = 0;
        drained    = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_reg(REG_TIMEOUT, tmo_set[ph]);
            write_reg(REG_WINDOW, win_set[ph]);
            if (ph == 2) begin
                // Receiver holds off while a fresh session keeps offering ticks.
                hold_asked++;
                send_item(ACT_CLEAR, $urandom, SEQ_W'($urandom), 1'b0, '0);
                repeat (6) send_item(ACT_LOAD, $urandom, SEQ_W'($urandom), 1'b0, '0);
                repeat (4) send_item(ACT_TICK, $urandom, SEQ_W'($urandom), 1'b0, '0);
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick_item(act, data, ackn);
                if (!(act == ACT_LOAD && shadow_loaded == MAX_PACKETS)
                        && !(act == ACT_ACK && ackn >= shadow_loaded)) begin
                    counted++;
                end
                send_item(act, data, ackn, 1'b0, '0);
                if (ph == 3 && counted >= ITEMS_PER_PHASE / 2 && !drained) begin
                    // Sender waits for every outstanding packet before going on.
                    drained = 1'b1;
                    s_tvalid <= 1'b0;
                    while (pending_pkts.size() != 0) @(negedge aclk);
                    @(negedge aclk);
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                        if (gap > 0) begin
                            pause_sender(gap);
                        end
                    end
                    burst_left--;
                end
            end
        end

        settle();
        $display("Run covered %0d items (%0d ticks); %0d packets checked, %0d of them resends.",
                 items_accepted, ticks_accepted, pkts_checked, resends_seen);
        $display("Window sizes from zero to saturation, timeouts from 0 to 32767, store full "
                 , "and a long receiver hold-off were exercised.");
        if (mismatch_count == 0 && pending_pkts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d packets never arrived.",
                     mismatch_count, pending_pkts.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### selective_repeat_sender_window.f
src/srsw_pkg.sv
src/selective_repeat_sender_window.sv
verif/testbench.sv
